// File: src/srx_pkg.sv
// shared constants and types for the sync length frame receiver
package srx_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int STORE_DEPTH = MAX_PAYLOAD + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 6;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] SECOND_BYTE = 8'h00;
  localparam logic [7:0] MAX_LEN     = 8'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_WAIT = 2'd1,
    PH_RECV = 2'd2,
    PH_EMIT = 2'd3
  } phase_t;

endpackage

// File: src/sync_length_frame_receiver.sv
// top level: sync hunt, length-prefixed frame store and frame emit
// a frame's first result follows its checksum byte through the emit phase, the frame store read and the output register
// throughput: one received byte per cycle while hunting or receiving
// emit: a new store read is issued only when no read is pending and the output register is free
// no input is taken while the stored frame is read out (L+1 reads)
// reset: rst_n synchronous, active low; back to hunting, check disabled, store left as is
module sync_length_frame_receiver (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_check_enable_we,
  input  logic                    cfg_check_enable,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_frame_byte,
  output logic [srx_pkg::IDX_W-1:0] out_byte_index,
  output logic                    out_checksum_ok,
  output logic                    out_last
);

  localparam int AW = srx_pkg::ADDR_W;
  localparam int IW = srx_pkg::IDX_W;

  srx_pkg::phase_t phase_r, phase_nxt;
  logic [IW-1:0]   widx_r, widx_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [IW-1:0]   len_r, len_nxt;
  logic            ok_r, ok_nxt;
  logic            chk_en_r;
  logic [IW-1:0]   em_idx_r, em_idx_nxt;
  logic            rd_pend_r;
  logic [IW-1:0]   rd_idx_r;
  logic [7:0]      rd_data_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r;
  logic [IW-1:0]   out_idx_r;
  logic            out_ok_r;
  logic            out_last_r;

  logic [7:0]      mem [srx_pkg::STORE_DEPTH];

  logic            in_acc;
  logic            out_free;
  logic            issue;
  logic            wr_en;
  logic [7:0]      cs_expect;
  logic            cs_ok;

  assign in_acc    = in_valid && (phase_r != srx_pkg::PH_EMIT);
  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = (phase_r == srx_pkg::PH_EMIT) && !rd_pend_r && out_free;
  assign cs_expect = 8'd0 - sum_r;
  assign cs_ok     = (cs_expect == in_rx_byte);

  always_comb begin
    phase_nxt  = phase_r;
    widx_nxt   = widx_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    ok_nxt     = ok_r;
    em_idx_nxt = em_idx_r;
    wr_en      = 1'b0;
    unique case (phase_r)
      srx_pkg::PH_HUNT: begin
        if (in_acc && in_rx_byte == srx_pkg::SYNC_BYTE) begin
          phase_nxt = srx_pkg::PH_WAIT;
        end
      end
      srx_pkg::PH_WAIT: begin
        if (in_acc && in_rx_byte == srx_pkg::SECOND_BYTE) begin
          phase_nxt = srx_pkg::PH_RECV;
          widx_nxt  = '0;
          sum_nxt   = '0;
        end
      end
      srx_pkg::PH_RECV: begin
        if (in_acc) begin
          if (widx_r == '0) begin
            if (in_rx_byte > srx_pkg::MAX_LEN) begin
              phase_nxt = srx_pkg::PH_HUNT;
              widx_nxt  = '0;
              sum_nxt   = '0;
            end else begin
              wr_en    = 1'b1;
              len_nxt  = in_rx_byte[IW-1:0];
              sum_nxt  = in_rx_byte;
              widx_nxt = IW'(1);
            end
          end else if (widx_r <= len_r) begin
            wr_en    = 1'b1;
            sum_nxt  = sum_r + in_rx_byte;
            widx_nxt = widx_r + IW'(1);
          end else begin
            // checksum byte
            ok_nxt     = cs_ok;
            widx_nxt   = '0;
            sum_nxt    = '0;
            em_idx_nxt = '0;
            if (chk_en_r && !cs_ok) begin
              phase_nxt = srx_pkg::PH_HUNT;
            end else begin
              phase_nxt = srx_pkg::PH_EMIT;
            end
          end
        end
      end
      srx_pkg::PH_EMIT: begin
        if (issue) begin
          em_idx_nxt = em_idx_r + IW'(1);
          if (em_idx_r == len_r) begin
            phase_nxt = srx_pkg::PH_HUNT;
          end
        end
      end
      default: begin
        phase_nxt = srx_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= srx_pkg::PH_HUNT;
      widx_r      <= '0;
      sum_r       <= '0;
      chk_en_r    <= 1'b0;
      em_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      widx_r      <= widx_nxt;
      sum_r       <= sum_nxt;
      em_idx_r    <= em_idx_nxt;
      rd_pend_r   <= issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_check_enable_we) begin
        chk_en_r <= cfg_check_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    ok_r  <= ok_nxt;
    if (issue) begin
      rd_idx_r <= em_idx_r;
    end
    if (rd_pend_r) begin
      out_byte_r <= rd_data_r;
      out_idx_r  <= rd_idx_r;
      out_ok_r   <= ok_r;
      out_last_r <= (rd_idx_r == len_r);
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[em_idx_r[AW-1:0]];
  end

  assign in_stall        = (phase_r == srx_pkg::PH_EMIT);
  assign out_valid       = out_valid_r;
  assign out_frame_byte  = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_checksum_ok = out_ok_r;
  assign out_last        = out_last_r;

endmodule

// File: src/srx_checker.sv
// port-level checks for the sync length frame receiver, bound to the top level
module srx_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [7:0]                in_rx_byte,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [7:0]                out_frame_byte,
  input logic [srx_pkg::IDX_W-1:0] out_byte_index,
  input logic                      out_checksum_ok,
  input logic                      out_last
);

  localparam logic [srx_pkg::IDX_W-1:0] MAX_IDX = srx_pkg::IDX_W'(srx_pkg::MAX_PAYLOAD);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("stalled request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte)
      && $stable(out_byte_index) && $stable(out_checksum_ok) && $stable(out_last))
    else $error("stalled result changed");

  // index never beyond the store
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_index <= MAX_IDX)
    else $error("byte index out of range");

  // length byte never above maximum
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_index == '0 |-> out_frame_byte <= srx_pkg::MAX_LEN)
    else $error("emitted length above maximum");

  // zero-length frame has a single result
  a_zero_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_index == '0 && out_frame_byte == 8'd0 |-> out_last)
    else $error("zero length frame without last");

endmodule

bind sync_length_frame_receiver srx_checker u_srx_checker (.*);

// File: tb/sync_length_frame_receiver_test.sv
// testbench for the sync length frame receiver: directed and random frames, scoreboard check
`timescale 1ns / 1ps

module sync_length_frame_receiver_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct {
    logic [7:0]                frame_byte;
    logic [srx_pkg::IDX_W-1:0] byte_index;
    logic                      checksum_ok;
    logic                      last;
  } frame_result_t;

  class frame_predictor;
    srx_pkg::phase_t ph;
    int              widx;
    logic [7:0]      rsum;
    logic [7:0]      store [srx_pkg::STORE_DEPTH];
    bit              check_en;
    frame_result_t   expected_bytes [$];
    int              errors;

    function new();
      ph       = srx_pkg::PH_HUNT;
      widx     = 0;
      rsum     = '0;
      check_en = 1'b0;
      errors   = 0;
    endfunction

    function void restart_hunt();
      ph   = srx_pkg::PH_HUNT;
      widx = 0;
      rsum = '0;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [7:0]    neg_sum;
      logic          ok;
      frame_result_t r;
      case (ph)
        srx_pkg::PH_WAIT: begin
          if (b == srx_pkg::SECOND_BYTE) begin
            ph   = srx_pkg::PH_RECV;
            widx = 0;
            rsum = '0;
          end
        end
        srx_pkg::PH_RECV: begin
          if (widx == 0) begin
            if (b > srx_pkg::MAX_LEN) begin
              restart_hunt();
            end else begin
              store[0] = b;
              rsum     = b;
              widx     = 1;
            end
          end else if (widx <= int'(store[0])) begin
            store[widx] = b;
            rsum        = rsum + b;
            widx++;
          end else begin
            neg_sum = 8'(0) - rsum;
            ok      = (neg_sum == b);
            restart_hunt();
            if (!(check_en && !ok)) begin
              for (int k = 0; k <= int'(store[0]); k++) begin
                r.frame_byte  = store[k];
                r.byte_index  = srx_pkg::IDX_W'(k);
                r.checksum_ok = ok;
                r.last        = (k == int'(store[0]));
                expected_bytes.push_back(r);
              end
            end
          end
        end
        default: begin
          if (b == srx_pkg::SYNC_BYTE) ph = srx_pkg::PH_WAIT;
        end
      endcase
    endfunction

    function void check_frame_byte(frame_result_t got);
      frame_result_t want;
      if (expected_bytes.size() == 0) begin
        $error("frame_byte %0h index %0d with no frame byte pending",
               got.frame_byte, got.byte_index);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
        $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
        errors++;
      end
      if (got.checksum_ok !== want.checksum_ok) begin
        $error("checksum_ok: expected %0b, got %0b", want.checksum_ok, got.checksum_ok);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_check_enable_we;
  logic                      cfg_check_enable;
  logic                      in_valid;
  logic                      in_stall;
  logic [7:0]                in_rx_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic [7:0]                out_frame_byte;
  logic [srx_pkg::IDX_W-1:0] out_byte_index;
  logic                      out_checksum_ok;
  logic                      out_last;

  frame_predictor fp;
  int             in_idle_pct;
  int             out_idle_pct;
  int             bytes_sent;
  int             quiet_cycles;

  sync_length_frame_receiver uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_check_enable_we (cfg_check_enable_we),
    .cfg_check_enable    (cfg_check_enable),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_byte      (out_frame_byte),
    .out_byte_index      (out_byte_index),
    .out_checksum_ok     (out_checksum_ok),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_check_enable_we = 1'b0;
    cfg_check_enable    = 1'b0;
    in_valid            = 1'b0;
    in_rx_byte          = '0;
    out_stall           = 1'b0;
    in_idle_pct         = 0;
    out_idle_pct        = 0;
    bytes_sent          = 0;
    quiet_cycles        = 0;
    fp                  = new();
  end

  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.frame_byte  = out_frame_byte;
      got.byte_index  = out_byte_index;
      got.checksum_ok = out_checksum_ok;
      got.last        = out_last;
      fp.check_frame_byte(got);
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    fp.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit good, input int junk);
    logic [7:0] sum;
    logic [7:0] d;
    send_byte(srx_pkg::SYNC_BYTE);
    repeat (junk) send_byte(8'($urandom_range(1, 255)));
    send_byte(srx_pkg::SECOND_BYTE);
    send_byte(8'(len));
    if (len <= srx_pkg::MAX_PAYLOAD) begin
      sum = 8'(len);
      for (int k = 0; k < len; k++) begin
        d = 8'($urandom);
        send_byte(d);
        sum = sum + d;
      end
      d = 8'(0) - sum;
      if (!good) d = d ^ 8'($urandom_range(1, 255));
      send_byte(d);
    end
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (fp.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_check_enable(input bit v);
    drain_requests();
    cfg_check_enable_we <= 1'b1;
    cfg_check_enable    <= v;
    @(posedge clk);
    fp.check_en = v;
    cfg_check_enable_we <= 1'b0;
  endtask

  task automatic run_random(input int n_bytes, input int in_pct, input int out_pct);
    int sel;
    int len;
    int stop_at;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at      = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        if ($urandom_range(9) == 0) len = srx_pkg::MAX_PAYLOAD;
        else if ($urandom_range(3) == 0) len = $urandom_range(srx_pkg::MAX_PAYLOAD);
        else len = $urandom_range(8);
        send_frame(len, $urandom_range(4) != 0,
                   ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (sel < 85) begin
        send_frame($urandom_range(srx_pkg::MAX_PAYLOAD + 1, 255), 1'b1, 0);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise while hunting, junk while waiting, zero length frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(srx_pkg::SYNC_BYTE);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(srx_pkg::SECOND_BYTE);
    send_byte(8'h00);
    send_byte(8'h00);
    // oversize lengths
    send_frame(srx_pkg::MAX_PAYLOAD + 1, 1'b1, 0);
    send_frame(255, 1'b1, 0);
    // sync and zero inside payload, bad checksum passed with verdict
    send_byte(srx_pkg::SYNC_BYTE);
    send_byte(srx_pkg::SECOND_BYTE);
    send_byte(8'h02);
    send_byte(srx_pkg::SYNC_BYTE);
    send_byte(srx_pkg::SECOND_BYTE);
    send_byte(8'h13);

    write_check_enable(1'b1);
    run_random(75, 21, 67);
    write_check_enable(1'b0);
    run_random(75, 67, 21);
    write_check_enable(1'b1);
    run_random(75, 0, 0);

    drain_requests();
    if (fp.errors == 0 && fp.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
